FILE: rtl/core/iee_pkg.sv
// Shared types, constants and helpers for the infix expression evaluator.
package iee_pkg;

	localparam int unsigned StackDepthDefault = 64;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned CharWidth = 8;
	localparam int unsigned StatusWidth = 3;
	localparam int unsigned OpWidth = 3;

	typedef enum logic [OpWidth-1:0] {
		OP_PAREN = 3'd0,
		OP_ADD   = 3'd1,
		OP_SUB   = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_POW   = 3'd5
	} op_t;

	typedef enum logic [StatusWidth-1:0] {
		ST_OK        = 3'd0,
		ST_DIV0      = 3'd1,
		ST_UNKNOWN   = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_MALFORMED = 3'd4
	} status_t;

	localparam logic [CharWidth-1:0] ChEnd    = 8'h40;
	localparam logic [CharWidth-1:0] ChPow    = 8'h5E;
	localparam logic [CharWidth-1:0] ChLParen = 8'h28;
	localparam logic [CharWidth-1:0] ChRParen = 8'h29;
	localparam logic [CharWidth-1:0] ChAdd    = 8'h2B;
	localparam logic [CharWidth-1:0] ChSub    = 8'h2D;
	localparam logic [CharWidth-1:0] ChMul    = 8'h2A;
	localparam logic [CharWidth-1:0] ChDiv    = 8'h2F;
	localparam logic [CharWidth-1:0] ChZero   = 8'h30;
	localparam logic [CharWidth-1:0] ChNine   = 8'h39;
	localparam logic [ValueWidth-1:0] Radix   = 64'd10;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_OP,
		S_RD_WAIT,
		S_CHECK,
		S_RD_A,
		S_RD_B,
		S_ALU,
		S_ALU_WAIT,
		S_WRITE,
		S_FINISH,
		S_RD_FINAL,
		S_FINAL_WAIT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		ALU_ARITH,
		ALU_DIV,
		ALU_POW
	} alu_kind_t;

	function automatic logic [1:0] prec_of(input logic [OpWidth-1:0] op);
		logic [1:0] p;
		p = 2'd0;
		if (op == OP_POW) begin
			p = 2'd3;
		end else if (op == OP_MUL || op == OP_DIV) begin
			p = 2'd2;
		end else if (op == OP_ADD || op == OP_SUB) begin
			p = 2'd1;
		end
		return p;
	endfunction

endpackage

FILE: rtl/core/iee_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module iee_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/core/iee_alu.sv
// Multi-cycle arithmetic unit: add, subtract, multiply, divide and power.
module iee_alu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [iee_pkg::OpWidth-1:0]  op,
	input  logic [iee_pkg::ValueWidth-1:0] a,
	input  logic [iee_pkg::ValueWidth-1:0] b,
	output logic                         done,
	output logic [iee_pkg::ValueWidth-1:0] result
);
	import iee_pkg::*;

	localparam int unsigned W = ValueWidth;
	localparam int unsigned CntW = $clog2(W) + 1;

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_POW_SQ,
		A_DONE
	} alu_state_t;

	alu_state_t state_q;
	logic [CntW-1:0] cnt_q;
	logic [W-1:0] acc_q, x_q, y_q, rem_q, quo_q, res_q;
	logic [W-1:0] mula_q, mulb_q;
	logic neg_q, pow_q;
	logic [1:0] mphase_q;
	logic [W-1:0] pp_ll_q, pp_lh_q, pp_hl_q;

	logic [W-1:0] mag_a, mag_b, rem_sh, rem_sub;
	logic         rem_ge;
	logic [W-1:0] mul_sum;

	assign mag_a = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b = b[W-1] ? (~b + 1'b1) : b;
	assign rem_sh = {rem_q[W-2:0], x_q[W-1]};
	assign rem_ge = (rem_sh >= y_q);
	assign rem_sub = rem_sh - y_q;
	assign mul_sum = pp_ll_q + {pp_lh_q[W/2-1:0], {(W/2){1'b0}}}
		+ {pp_hl_q[W/2-1:0], {(W/2){1'b0}}};

	// The 64-bit multiply is done as three 32x32 partial products over cycles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			mphase_q <= 2'd0;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (start) begin
						pow_q <= 1'b0;
						case (op)
							OP_ADD: begin
								res_q <= a + b;
								state_q <= A_DONE;
							end
							OP_SUB: begin
								res_q <= a - b;
								state_q <= A_DONE;
							end
							OP_MUL: begin
								mula_q <= a;
								mulb_q <= b;
								mphase_q <= 2'd0;
								state_q <= A_MUL;
							end
							OP_DIV: begin
								x_q <= mag_a;
								y_q <= mag_b;
								rem_q <= '0;
								quo_q <= '0;
								neg_q <= a[W-1] ^ b[W-1];
								cnt_q <= CntW'(W);
								state_q <= A_DIV;
							end
							default: begin
								if (b[W-1]) begin
									if (a == W'(1)) begin
										res_q <= W'(1);
									end else if (a == '1) begin
										res_q <= b[0] ? a : W'(1);
									end else begin
										res_q <= '0;
									end
									state_q <= A_DONE;
								end else begin
									acc_q <= W'(1);
									x_q <= a;
									y_q <= b;
									cnt_q <= '0;
									pow_q <= 1'b1;
									state_q <= A_POW_SQ;
								end
							end
						endcase
					end
				end
				A_MUL: begin
					case (mphase_q)
						2'd0: begin
							pp_ll_q <= W'(mula_q[W/2-1:0]) * W'(mulb_q[W/2-1:0]);
							mphase_q <= 2'd1;
						end
						2'd1: begin
							pp_lh_q <= W'(mula_q[W/2-1:0]) * W'(mulb_q[W-1:W/2]);
							mphase_q <= 2'd2;
						end
						2'd2: begin
							pp_hl_q <= W'(mula_q[W-1:W/2]) * W'(mulb_q[W/2-1:0]);
							mphase_q <= 2'd3;
						end
						default: begin
							mphase_q <= 2'd0;
							if (pow_q) begin
								// Either the running product or the square finished.
								if (mulb_q == x_q && !cnt_q[0]) begin
									x_q <= mul_sum;
									y_q <= y_q >> 1;
								end else begin
									acc_q <= mul_sum;
								end
								state_q <= A_POW_SQ;
							end else begin
								res_q <= mul_sum;
								state_q <= A_DONE;
							end
						end
					endcase
				end
				A_DIV: begin
					x_q <= {x_q[W-2:0], 1'b0};
					rem_q <= rem_ge ? rem_sub : rem_sh;
					quo_q <= {quo_q[W-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntW'(1)) begin
						res_q <= neg_q ? (~{quo_q[W-2:0], rem_ge} + 1'b1)
							: {quo_q[W-2:0], rem_ge};
						state_q <= A_DONE;
					end
				end
				A_POW_SQ: begin
					// cnt_q[0] marks that the product step for this bit is done.
					if (y_q == '0) begin
						res_q <= acc_q;
						state_q <= A_DONE;
					end else if (y_q[0] && !cnt_q[0]) begin
						mula_q <= acc_q;
						mulb_q <= x_q;
						cnt_q[0] <= 1'b1;
						state_q <= A_MUL;
					end else begin
						mula_q <= x_q;
						mulb_q <= x_q;
						cnt_q[0] <= 1'b0;
						state_q <= A_MUL;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done = (state_q == A_DONE);
	assign result = res_q;
endmodule

FILE: rtl/core/iee_datapath.sv
// Datapath: stacks, counters, digit accumulator, error register and output word.
module iee_datapath #(
	parameter int unsigned STACK_DEPTH = iee_pkg::StackDepthDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [iee_pkg::CharWidth-1:0]   character,
	input  logic                            in_take,
	input  iee_pkg::state_t                 state,
	output logic [iee_pkg::CharWidth-1:0]   char_q_o,
	output logic [iee_pkg::OpWidth-1:0]     top_op,
	output logic                            opd_lt2,
	output logic                            opr_empty,
	output logic                            err_set,
	output logic                            alu_done,
	output logic [iee_pkg::ValueWidth-1:0]  value,
	output logic [iee_pkg::StatusWidth-1:0] status
);
	import iee_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [CharWidth-1:0] char_q;
	logic [CW-1:0] opd_cnt_q, opr_cnt_q;
	logic [ValueWidth-1:0] acc_q, a_q, b_q, value_q;
	logic pend_q;
	logic [StatusWidth-1:0] err_q, status_q;
	logic [OpWidth-1:0] op_q, new_op;

	logic opd_we, opr_we;
	logic [AW-1:0] opd_waddr, opd_raddr, opr_waddr, opr_raddr;
	logic [ValueWidth-1:0] opd_wdata, opd_rdata, alu_res;
	logic [OpWidth-1:0] opr_wdata, opr_rdata;
	logic alu_start;

	logic is_digit, is_op;
	assign is_digit = (char_q >= ChZero) && (char_q <= ChNine);
	assign is_op = (char_q == ChAdd) || (char_q == ChSub) || (char_q == ChMul)
		|| (char_q == ChDiv) || (char_q == ChPow);

	always_comb begin
		case (char_q)
			ChAdd: new_op = OP_ADD;
			ChSub: new_op = OP_SUB;
			ChMul: new_op = OP_MUL;
			ChDiv: new_op = OP_DIV;
			default: new_op = OP_POW;
		endcase
	end

	// Operand flushes and '(' pushes happen in S_DECODE, operator pushes in S_FINISH.
	logic do_write;
	logic opd_full, opr_full, err_ok;
	assign err_ok = (err_q == ST_OK);
	assign opd_full = (opd_cnt_q == CW'(STACK_DEPTH));
	assign opr_full = (opr_cnt_q == CW'(STACK_DEPTH));
	assign do_write = (state == S_WRITE);
	assign alu_start = (state == S_ALU);

	always_comb begin
		opd_we = 1'b0;
		opd_waddr = opd_cnt_q[AW-1:0];
		opd_wdata = acc_q;
		if (state == S_DECODE && pend_q && err_ok && !opd_full
				&& (is_op || char_q == ChRParen || char_q == ChEnd)) begin
			opd_we = 1'b1;
		end
		if (do_write) begin
			opd_we = 1'b1;
			opd_waddr = AW'(opd_cnt_q - CW'(2));
			opd_wdata = alu_res;
		end
	end

	assign opr_we = (state == S_FINISH) && err_ok && is_op && !opr_full
		|| (state == S_DECODE) && err_ok && (char_q == ChLParen) && !pend_q
			&& !opr_full;
	assign opr_waddr = opr_cnt_q[AW-1:0];
	assign opr_wdata = (char_q == ChLParen) ? OP_PAREN : new_op;

	always_comb begin
		opr_raddr = AW'(opr_cnt_q - CW'(1));
		opd_raddr = AW'(opd_cnt_q - CW'(1));
		if (state == S_RD_A) begin
			opd_raddr = AW'(opd_cnt_q - CW'(2));
		end else if (state == S_RD_FINAL) begin
			opd_raddr = '0;
		end
	end

	iee_ram #(.WIDTH(ValueWidth), .DEPTH(STACK_DEPTH)) u_opd (
		.clk(clk), .we(opd_we), .waddr(opd_waddr), .wdata(opd_wdata),
		.raddr(opd_raddr), .rdata(opd_rdata)
	);
	iee_ram #(.WIDTH(OpWidth), .DEPTH(STACK_DEPTH)) u_opr (
		.clk(clk), .we(opr_we), .waddr(opr_waddr), .wdata(opr_wdata),
		.raddr(opr_raddr), .rdata(opr_rdata)
	);
	iee_alu u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .op(op_q),
		.a(a_q), .b(b_q), .done(alu_done), .result(alu_res)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_q <= character;
		end
		if (state == S_RD_WAIT) begin
			op_q <= opr_rdata;
		end
		if (state == S_RD_B) begin
			a_q <= opd_rdata;
		end
		if (state == S_RD_A) begin
			b_q <= opd_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opd_cnt_q <= '0;
			opr_cnt_q <= '0;
			acc_q <= '0;
			pend_q <= 1'b0;
			err_q <= ST_OK;
			value_q <= '0;
			status_q <= ST_OK;
		end else begin
			case (state)
				S_DECODE: begin
					if (err_ok && char_q != ChEnd) begin
						if (is_digit) begin
							acc_q <= (acc_q << 3) + (acc_q << 1)
								+ ValueWidth'(char_q - ChZero);
							pend_q <= 1'b1;
						end else if (char_q == ChLParen) begin
							if (pend_q) begin
								err_q <= ST_MALFORMED;
							end else if (opr_full) begin
								err_q <= ST_OVERFLOW;
							end else begin
								opr_cnt_q <= opr_cnt_q + 1'b1;
							end
						end else if (!(is_op || char_q == ChRParen)) begin
							err_q <= ST_UNKNOWN;
						end
					end
					if (err_ok && pend_q && (is_op || char_q == ChRParen || char_q == ChEnd)) begin
						acc_q <= '0;
						pend_q <= 1'b0;
						if (opd_full) begin
							err_q <= ST_OVERFLOW;
						end else begin
							opd_cnt_q <= opd_cnt_q + 1'b1;
						end
					end
				end
				S_CHECK: begin
					// Reduction guards, and the closing-paren pop.
					if (err_ok) begin
						if (char_q == ChRParen && !opr_empty && op_q == OP_PAREN) begin
							opr_cnt_q <= opr_cnt_q - 1'b1;
						end else if (!opr_empty && op_q != OP_PAREN && opd_lt2
								&& (char_q == ChEnd || char_q == ChRParen
									|| prec_of(op_q) >= prec_of(new_op))) begin
							err_q <= ST_MALFORMED;
						end else if (char_q == ChEnd && !opr_empty
								&& op_q == OP_PAREN) begin
							err_q <= ST_MALFORMED;
						end else if (char_q == ChRParen && opr_empty) begin
							err_q <= ST_MALFORMED;
						end
					end
				end
				S_ALU_WAIT: begin
					if (alu_done && op_q == OP_DIV && b_q == '0) begin
						err_q <= ST_DIV0;
					end
				end
				S_WRITE: begin
					opd_cnt_q <= opd_cnt_q - 1'b1;
					opr_cnt_q <= opr_cnt_q - 1'b1;
				end
				S_FINISH: begin
					if (err_ok && is_op) begin
						if (opr_full) begin
							err_q <= ST_OVERFLOW;
						end else begin
							opr_cnt_q <= opr_cnt_q + 1'b1;
						end
					end
				end
				S_FINAL_WAIT: begin
					if (err_ok && opd_cnt_q == CW'(1)) begin
						value_q <= opd_rdata;
						status_q <= ST_OK;
					end else begin
						value_q <= '0;
						status_q <= err_ok ? ST_MALFORMED : err_q;
					end
					opd_cnt_q <= '0;
					opr_cnt_q <= '0;
					acc_q <= '0;
					pend_q <= 1'b0;
					err_q <= ST_OK;
				end
				default: begin
				end
			endcase
		end
	end

	assign char_q_o = char_q;
	assign top_op = op_q;
	assign opd_lt2 = (opd_cnt_q < CW'(2));
	assign opr_empty = (opr_cnt_q == '0);
	assign err_set = !err_ok || (alu_done && op_q == OP_DIV && b_q == '0);
	assign value = value_q;
	assign status = status_q;
endmodule

FILE: rtl/core/iee_ctrl.sv
// Controller state machine sequencing decode, reductions and the final result.
module iee_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic [iee_pkg::CharWidth-1:0] char_q,
	input  logic [iee_pkg::OpWidth-1:0]   top_op,
	input  logic                          opd_lt2,
	input  logic                          opr_empty,
	input  logic                          err_set,
	input  logic                          alu_done,
	output iee_pkg::state_t               state
);
	import iee_pkg::*;

	state_t state_q, state_d;
	logic is_op, reduce_ok;

	assign is_op = (char_q == ChAdd) || (char_q == ChSub) || (char_q == ChMul)
		|| (char_q == ChDiv) || (char_q == ChPow);

	logic [OpWidth-1:0] new_op;
	always_comb begin
		case (char_q)
			ChAdd: new_op = OP_ADD;
			ChSub: new_op = OP_SUB;
			ChMul: new_op = OP_MUL;
			ChDiv: new_op = OP_DIV;
			default: new_op = OP_POW;
		endcase
	end

	// Whether the top operator is to be reduced for the current character.
	assign reduce_ok = !opr_empty && top_op != OP_PAREN
		&& (char_q == ChEnd || char_q == ChRParen || prec_of(top_op) >= prec_of(new_op));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (char_q == ChEnd || is_op || char_q == ChRParen) begin
					state_d = S_RD_OP;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_RD_OP: begin
				state_d = S_RD_WAIT;
			end
			S_RD_WAIT: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (err_set) begin
					state_d = S_FINISH;
				end else if (reduce_ok && !opd_lt2) begin
					state_d = S_RD_A;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_RD_A: begin
				state_d = S_RD_B;
			end
			S_RD_B: begin
				state_d = S_ALU;
			end
			S_ALU: begin
				state_d = S_ALU_WAIT;
			end
			S_ALU_WAIT: begin
				if (alu_done) begin
					state_d = err_set ? S_FINISH : S_WRITE;
				end
			end
			S_WRITE: begin
				state_d = S_RD_OP;
			end
			S_FINISH: begin
				state_d = (char_q == ChEnd) ? S_RD_FINAL : S_IDLE;
			end
			S_RD_FINAL: begin
				state_d = S_FINAL_WAIT;
			end
			S_FINAL_WAIT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
	end

	assign state = state_q;

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid;
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");

	a_write_after_alu: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |-> $past(state_q) == S_ALU_WAIT)
		else $error("stack write without a finished operation");
endmodule

FILE: rtl/core/infix_expression_evaluator_unit.sv
// Top level of the infix expression evaluator.
// Usage: one ASCII character per input word on character/in_valid/in_ready.
// Digits, + - * / ^ and parentheses build the expression; '@' ends it and
// produces one result word (value, status) on out_valid/out_ready.
// Other characters produce no output word.
// A digit is accumulated and '(' is pushed in decode. An operator, ')' or '@'
// reads and checks the top operator, then for each reduction reads both
// operands, runs the arithmetic unit and writes the result back: + or -
// directly, * as three partial products, / bit by bit, and ^ by squaring and
// multiplying with up to two multiplies per exponent bit. For '@', once nothing
// is left to reduce, the bottom operand is read and registered as the result.
// The stacks are RAMs with one read port, so each reduction reads the
// operator and both operands in turn.
// After '@' the result waits in its register until taken; no new character
// is accepted while it waits. Reset clears the counts, the accumulator and
// the error; stack contents need no clearing.
module infix_expression_evaluator_unit #(
	parameter int unsigned STACK_DEPTH = iee_pkg::StackDepthDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [iee_pkg::CharWidth-1:0]   character,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [iee_pkg::ValueWidth-1:0]  value,
	output logic [iee_pkg::StatusWidth-1:0] status
);
	import iee_pkg::*;

	state_t state;
	logic [CharWidth-1:0] char_q;
	logic [OpWidth-1:0] top_op;
	logic opd_lt2, opr_empty, err_set, alu_done;

	iee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .char_q(char_q),
		.top_op(top_op), .opd_lt2(opd_lt2), .opr_empty(opr_empty),
		.err_set(err_set), .alu_done(alu_done), .state(state)
	);

	iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .character(character),
		.in_take(in_valid && in_ready), .state(state), .char_q_o(char_q),
		.top_op(top_op), .opd_lt2(opd_lt2), .opr_empty(opr_empty),
		.err_set(err_set), .alu_done(alu_done), .value(value), .status(status)
	);
endmodule
